// ===== rtl/rk4_pkg.sv =====
// Shared constants, latencies and the pipeline control type for the RK4 step unit.
// No dependencies; every other file refers to it by scoped names.
package rk4_pkg;

  localparam int WORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int STEP_BITS = 17;
  localparam logic [STEP_BITS-1:0] STEP_RESET = 17'd6554;

  localparam int MUL_LAT   = 3;
  localparam int SLOPE_LAT = 2 * MUL_LAT + 1;
  localparam int PRE_LAT   = 2;

  localparam int DIV_DIGITS = 8;
  localparam int DIV_EDGE   = 6;
  localparam int DIV_MID    = 3;

  typedef struct packed {
    logic valid;
    logic ovf;
  } ctl_t;

endpackage

// ===== rtl/rk4_sat_add.sv =====
// Saturating signed adder of two words with an overflow flag.
// Uses rk4_pkg for the default word width.
module rk4_sat_add #(
  parameter int WORD_WIDTH = rk4_pkg::WORD_WIDTH_DEF
) (
  input  logic signed [WORD_WIDTH-1:0] a,
  input  logic signed [WORD_WIDTH-1:0] b,
  output logic signed [WORD_WIDTH-1:0] sum,
  output logic                         sat
);

  logic signed [WORD_WIDTH:0] full;

  assign full = {a[WORD_WIDTH-1], a} + {b[WORD_WIDTH-1], b};
  assign sat  = full[WORD_WIDTH] ^ full[WORD_WIDTH-1];
  assign sum  = sat ? {full[WORD_WIDTH], {(WORD_WIDTH-1){~full[WORD_WIDTH]}}}
                    : full[WORD_WIDTH-1:0];

endmodule

// ===== rtl/rk4_mul.sv =====
// Three-stage signed fixed-point multiplier: half-word partial products, rounded sum,
// then saturation and sign. Uses rk4_pkg for default widths.
module rk4_mul #(
  parameter int WORD_WIDTH = rk4_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = rk4_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [WORD_WIDTH-1:0] a,
  input  logic signed [WORD_WIDTH-1:0] b,
  output logic signed [WORD_WIDTH-1:0] p,
  output logic                         sat
);

  localparam int LO_W = WORD_WIDTH / 2;
  localparam int HI_W = WORD_WIDTH - LO_W;
  localparam int PW   = 2 * WORD_WIDTH;
  localparam int QW   = PW - FRAC_BITS;
  localparam logic [PW-1:0] RND = PW'(1) << (FRAC_BITS - 1);

  logic [WORD_WIDTH-1:0]      ma;
  logic [WORD_WIDTH-1:0]      mb;
  logic [2*LO_W-1:0]          ll;
  logic [LO_W+HI_W-1:0]       lh;
  logic [LO_W+HI_W-1:0]       hl;
  logic [2*HI_W-1:0]          hh;
  logic                       neg1;
  logic [PW-1:0]              sum;
  logic [QW-1:0]              q;
  logic                       neg2;
  logic                       over;
  logic signed [WORD_WIDTH-1:0] p_next;

  assign ma = a[WORD_WIDTH-1] ? WORD_WIDTH'(-a) : WORD_WIDTH'(a);
  assign mb = b[WORD_WIDTH-1] ? WORD_WIDTH'(-b) : WORD_WIDTH'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      ll   <= ma[LO_W-1:0] * mb[LO_W-1:0];
      lh   <= ma[LO_W-1:0] * mb[WORD_WIDTH-1:LO_W];
      hl   <= ma[WORD_WIDTH-1:LO_W] * mb[LO_W-1:0];
      hh   <= ma[WORD_WIDTH-1:LO_W] * mb[WORD_WIDTH-1:LO_W];
      neg1 <= a[WORD_WIDTH-1] ^ b[WORD_WIDTH-1];
    end
  end

  assign sum = (PW'(hh) << (2 * LO_W)) + (PW'(lh) << LO_W) + (PW'(hl) << LO_W)
             + PW'(ll) + RND;

  always_ff @(posedge clk) begin
    if (en) begin
      q    <= sum[PW-1:FRAC_BITS];
      neg2 <= neg1;
    end
  end

  always_comb begin
    if (neg2) begin
      over = (|q[QW-1:WORD_WIDTH]) | (q[WORD_WIDTH-1] & (|q[WORD_WIDTH-2:0]));
    end else begin
      over = |q[QW-1:WORD_WIDTH-1];
    end
    if (over) begin
      p_next = neg2 ? {1'b1, {(WORD_WIDTH-1){1'b0}}} : {1'b0, {(WORD_WIDTH-1){1'b1}}};
    end else begin
      p_next = neg2 ? -q[WORD_WIDTH-1:0] : q[WORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p   <= p_next;
      sat <= over;
    end
  end

endmodule

// ===== rtl/rk4_delay.sv =====
// Enabled shift line that aligns a value with a later pipeline stage.
// Uses rk4_pkg for default width and depth.
module rk4_delay #(
  parameter int WIDTH = rk4_pkg::WORD_WIDTH_DEF,
  parameter int DEPTH = rk4_pkg::MUL_LAT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        line[i] <= '0;
      end
    end else if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

// ===== rtl/rk4_slope.sv =====
// Slope pipeline k = h * (x*x + y*y) with saturation, seven stages deep.
// Depends on rk4_pkg, rk4_mul, rk4_sat_add and rk4_delay.
module rk4_slope #(
  parameter int WORD_WIDTH = rk4_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = rk4_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic signed [WORD_WIDTH-1:0] h,
  input  logic signed [WORD_WIDTH-1:0] x,
  input  logic signed [WORD_WIDTH-1:0] y,
  input  rk4_pkg::ctl_t                ctl_in,
  output logic signed [WORD_WIDTH-1:0] k,
  output rk4_pkg::ctl_t                ctl_out
);

  logic signed [WORD_WIDTH-1:0] xx;
  logic signed [WORD_WIDTH-1:0] yy;
  logic signed [WORD_WIDTH-1:0] f_sum;
  logic signed [WORD_WIDTH-1:0] f;
  logic                         xx_sat;
  logic                         yy_sat;
  logic                         f_sat;
  logic                         k_sat;
  rk4_pkg::ctl_t                ctl_a;
  rk4_pkg::ctl_t                ctl_f;
  rk4_pkg::ctl_t                ctl_b;

  rk4_mul #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_xx (
    .clk(clk), .en(en), .a(x), .b(x), .p(xx), .sat(xx_sat)
  );

  rk4_mul #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_yy (
    .clk(clk), .en(en), .a(y), .b(y), .p(yy), .sat(yy_sat)
  );

  rk4_delay #(.WIDTH($bits(rk4_pkg::ctl_t)), .DEPTH(rk4_pkg::MUL_LAT)) u_ctl_a (
    .clk(clk), .rst(rst), .en(en), .d(ctl_in), .q(ctl_a)
  );

  rk4_sat_add #(.WORD_WIDTH(WORD_WIDTH)) u_f (
    .a(xx), .b(yy), .sum(f_sum), .sat(f_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_f <= '0;
    end else if (en) begin
      ctl_f.valid <= ctl_a.valid;
      ctl_f.ovf   <= ctl_a.ovf | xx_sat | yy_sat | f_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f <= f_sum;
    end
  end

  rk4_mul #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_hf (
    .clk(clk), .en(en), .a(h), .b(f), .p(k), .sat(k_sat)
  );

  rk4_delay #(.WIDTH($bits(rk4_pkg::ctl_t)), .DEPTH(rk4_pkg::MUL_LAT)) u_ctl_b (
    .clk(clk), .rst(rst), .en(en), .d(ctl_f), .q(ctl_b)
  );

  assign ctl_out.valid = ctl_b.valid;
  assign ctl_out.ovf   = ctl_b.ovf | k_sat;

endmodule

// ===== rtl/rk4_pre.sv =====
// Two-stage predictor input y + k/2, halving rounded on the magnitude, sum saturated.
// Depends on rk4_pkg and rk4_sat_add.
module rk4_pre #(
  parameter int WORD_WIDTH = rk4_pkg::WORD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic signed [WORD_WIDTH-1:0] y,
  input  logic signed [WORD_WIDTH-1:0] k,
  input  rk4_pkg::ctl_t                ctl_in,
  output logic signed [WORD_WIDTH-1:0] y_out,
  output rk4_pkg::ctl_t                ctl_out
);

  logic [WORD_WIDTH-1:0]        k_mag;
  logic [WORD_WIDTH-1:0]        half_mag;
  logic signed [WORD_WIDTH-1:0] half_next;
  logic signed [WORD_WIDTH-1:0] half;
  logic signed [WORD_WIDTH-1:0] y_hold;
  logic signed [WORD_WIDTH-1:0] y_sum;
  logic                         y_sat;
  rk4_pkg::ctl_t                ctl_a;

  assign k_mag     = k[WORD_WIDTH-1] ? WORD_WIDTH'(-k) : WORD_WIDTH'(k);
  assign half_mag  = WORD_WIDTH'(({1'b0, k_mag} + (WORD_WIDTH+1)'(1)) >> 1);
  assign half_next = k[WORD_WIDTH-1] ? -half_mag : half_mag;

  always_ff @(posedge clk) begin
    if (en) begin
      half   <= half_next;
      y_hold <= y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
    end else if (en) begin
      ctl_a <= ctl_in;
    end
  end

  rk4_sat_add #(.WORD_WIDTH(WORD_WIDTH)) u_add (
    .a(y_hold), .b(half), .sum(y_sum), .sat(y_sat)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      y_out <= y_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out.valid <= ctl_a.valid;
      ctl_out.ovf   <= ctl_a.ovf | y_sat;
    end
  end

endmodule

// ===== rtl/rk4_cdiv.sv =====
// Pipelined signed division by a small constant, rounded to nearest on the magnitude,
// a byte of quotient bits per stage. Depends on rk4_pkg.
module rk4_cdiv #(
  parameter int WORD_WIDTH = rk4_pkg::WORD_WIDTH_DEF,
  parameter int DIVISOR    = rk4_pkg::DIV_MID
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [WORD_WIDTH-1:0] v,
  output logic signed [WORD_WIDTH-1:0] q
);

  localparam int DIGITS = rk4_pkg::DIV_DIGITS;
  localparam int STAGES = (WORD_WIDTH + DIGITS - 1) / DIGITS;
  localparam int RW     = $clog2(DIVISOR);
  localparam logic [RW:0]           DIV_C = (RW+1)'(DIVISOR);
  localparam logic [WORD_WIDTH-1:0] BIAS  = WORD_WIDTH'(DIVISOR / 2);

  logic [WORD_WIDTH-1:0] mag;
  logic [RW-1:0]         rem      [STAGES+1];
  logic [WORD_WIDTH-1:0] num      [STAGES+1];
  logic [WORD_WIDTH-1:0] quo      [STAGES+1];
  logic                  neg      [STAGES+1];
  logic [RW-1:0]         rem_next [STAGES];
  logic [WORD_WIDTH-1:0] num_next [STAGES];
  logic [WORD_WIDTH-1:0] quo_next [STAGES];

  assign mag = v[WORD_WIDTH-1] ? WORD_WIDTH'(-v) : WORD_WIDTH'(v);

  always_comb begin
    logic [RW:0] trial;
    trial = '0;
    for (int s = 0; s < STAGES; s++) begin
      rem_next[s] = rem[s];
      num_next[s] = num[s];
      quo_next[s] = quo[s];
      for (int i = 0; i < DIGITS; i++) begin
        if (s * DIGITS + i < WORD_WIDTH) begin
          trial       = {rem_next[s], num_next[s][WORD_WIDTH-1]};
          num_next[s] = {num_next[s][WORD_WIDTH-2:0], 1'b0};
          if (trial >= DIV_C) begin
            rem_next[s] = RW'(trial - DIV_C);
            quo_next[s] = {quo_next[s][WORD_WIDTH-2:0], 1'b1};
          end else begin
            rem_next[s] = trial[RW-1:0];
            quo_next[s] = {quo_next[s][WORD_WIDTH-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      num[0] <= mag + BIAS;
      quo[0] <= '0;
      neg[0] <= v[WORD_WIDTH-1];
      for (int s = 0; s < STAGES; s++) begin
        rem[s+1] <= rem_next[s];
        num[s+1] <= num_next[s];
        quo[s+1] <= quo_next[s];
        neg[s+1] <= neg[s];
      end
      q <= neg[STAGES] ? -quo[STAGES] : quo[STAGES];
    end
  end

endmodule

// ===== rtl/rk4_ode_step_unit.sv =====
// RK4 step unit for dy/dx = x*x + y*y in signed fixed point; depends on rk4_pkg and all rk4_ modules.
// Between accepted request and result lie an input register, four seven-stage slope pipelines,
// three predictor adds, the constant dividers and four sum stages.
// Throughput one request per cycle; the whole pipeline holds while a result is stalled.
// Synchronous reset clears all valid bits and loads step_size with 6554.
module rk4_ode_step_unit #(
  parameter int WORD_WIDTH = rk4_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = rk4_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [WORD_WIDTH-1:0]      x_now,
  input  logic signed [WORD_WIDTH-1:0]      y_now,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [WORD_WIDTH-1:0]      y_next,
  output logic signed [WORD_WIDTH-1:0]      x_next,
  output logic                              overflow,
  input  logic                              cfg_wr_en,
  input  logic [rk4_pkg::STEP_BITS-1:0]     cfg_wr_data
);

  localparam int S       = rk4_pkg::SLOPE_LAT;
  localparam int P       = rk4_pkg::PRE_LAT;
  localparam int DIV_LAT = (WORD_WIDTH + rk4_pkg::DIV_DIGITS - 1) / rk4_pkg::DIV_DIGITS + 2;
  localparam int CW      = WORD_WIDTH + rk4_pkg::STEP_BITS;
  localparam logic [CW-1:0] VMAX_C = CW'({1'b0, {(WORD_WIDTH-1){1'b1}}});

  logic [rk4_pkg::STEP_BITS-1:0] step_size;
  logic                          en;

  logic                          h_sat;
  logic signed [WORD_WIDTH-1:0]  h;
  logic [WORD_WIDTH-1:0]         h_inc;
  logic signed [WORD_WIDTH-1:0]  hh;

  logic                          v0;
  logic signed [WORD_WIDTH-1:0]  x0;
  logic signed [WORD_WIDTH-1:0]  y0;
  logic signed [WORD_WIDTH-1:0]  xh;
  logic signed [WORD_WIDTH-1:0]  xn;
  logic                          xh_sat;
  logic                          xn_sat;
  rk4_pkg::ctl_t                 c0;

  logic signed [WORD_WIDTH-1:0]  k1, k2, k3, k4;
  rk4_pkg::ctl_t                 c1, c2, c3, c4;
  logic signed [WORD_WIDTH-1:0]  y2, y3, y4, y4_sum;
  rk4_pkg::ctl_t                 c2p, c3p, c4p;
  logic                          y4_sat;

  logic signed [WORD_WIDTH-1:0]  ya, yb, yc, yd;
  logic signed [WORD_WIDTH-1:0]  xh_a, xh_b, xn_a, xn_b;
  logic signed [WORD_WIDTH-1:0]  k1d, k2d, k3d;
  logic signed [WORD_WIDTH-1:0]  q1, q2, q3, q4;
  rk4_pkg::ctl_t                 cq;

  logic signed [WORD_WIDTH-1:0]  a1, a2, a3, a4;
  logic                          s1, s2, s3, s4;
  logic signed [WORD_WIDTH-1:0]  e1_acc, e1_q2, e1_q3, e1_q4, e1_x;
  logic signed [WORD_WIDTH-1:0]  e2_acc, e2_q3, e2_q4, e2_x;
  logic signed [WORD_WIDTH-1:0]  e3_acc, e3_q4, e3_x;
  rk4_pkg::ctl_t                 e1_ctl, e2_ctl, e3_ctl;

  assign en       = ~(out_valid & out_stall);
  assign in_stall = ~en;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= rk4_pkg::STEP_RESET;
    end else if (cfg_wr_en) begin
      step_size <= cfg_wr_data;
    end
  end

  assign h_sat = CW'(step_size) > VMAX_C;
  assign h     = h_sat ? {1'b0, {(WORD_WIDTH-1){1'b1}}} : WORD_WIDTH'(step_size);
  assign h_inc = WORD_WIDTH'(h) + WORD_WIDTH'(1);
  assign hh    = {1'b0, h_inc[WORD_WIDTH-1:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0 <= x_now;
      y0 <= y_now;
    end
  end

  rk4_sat_add #(.WORD_WIDTH(WORD_WIDTH)) u_xh (
    .a(x0), .b(hh), .sum(xh), .sat(xh_sat)
  );

  rk4_sat_add #(.WORD_WIDTH(WORD_WIDTH)) u_xn (
    .a(x0), .b(h), .sum(xn), .sat(xn_sat)
  );

  assign c0.valid = v0;
  assign c0.ovf   = h_sat | xh_sat | xn_sat;

  // k1
  rk4_slope #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_k1 (
    .clk(clk), .rst(rst), .en(en), .h(h), .x(x0), .y(y0),
    .ctl_in(c0), .k(k1), .ctl_out(c1)
  );

  rk4_delay #(.WIDTH(WORD_WIDTH), .DEPTH(S)) u_dy_a (
    .clk(clk), .rst(rst), .en(en), .d(y0), .q(ya)
  );

  rk4_pre #(.WORD_WIDTH(WORD_WIDTH)) u_pre2 (
    .clk(clk), .rst(rst), .en(en), .y(ya), .k(k1), .ctl_in(c1),
    .y_out(y2), .ctl_out(c2p)
  );

  rk4_delay #(.WIDTH(WORD_WIDTH), .DEPTH(S + P)) u_dxh_a (
    .clk(clk), .rst(rst), .en(en), .d(xh), .q(xh_a)
  );

  // k2
  rk4_slope #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_k2 (
    .clk(clk), .rst(rst), .en(en), .h(h), .x(xh_a), .y(y2),
    .ctl_in(c2p), .k(k2), .ctl_out(c2)
  );

  rk4_delay #(.WIDTH(WORD_WIDTH), .DEPTH(S + P)) u_dy_b (
    .clk(clk), .rst(rst), .en(en), .d(ya), .q(yb)
  );

  rk4_pre #(.WORD_WIDTH(WORD_WIDTH)) u_pre3 (
    .clk(clk), .rst(rst), .en(en), .y(yb), .k(k2), .ctl_in(c2),
    .y_out(y3), .ctl_out(c3p)
  );

  rk4_delay #(.WIDTH(WORD_WIDTH), .DEPTH(S + P)) u_dxh_b (
    .clk(clk), .rst(rst), .en(en), .d(xh_a), .q(xh_b)
  );

  // k3
  rk4_slope #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_k3 (
    .clk(clk), .rst(rst), .en(en), .h(h), .x(xh_b), .y(y3),
    .ctl_in(c3p), .k(k3), .ctl_out(c3)
  );

  rk4_delay #(.WIDTH(WORD_WIDTH), .DEPTH(S + P)) u_dy_c (
    .clk(clk), .rst(rst), .en(en), .d(yb), .q(yc)
  );

  rk4_sat_add #(.WORD_WIDTH(WORD_WIDTH)) u_y4 (
    .a(yc), .b(k3), .sum(y4_sum), .sat(y4_sat)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      y4 <= y4_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c4p <= '0;
    end else if (en) begin
      c4p.valid <= c3.valid;
      c4p.ovf   <= c3.ovf | y4_sat;
    end
  end

  rk4_delay #(.WIDTH(WORD_WIDTH), .DEPTH(3 * S + 2 * P + 1)) u_dxn_a (
    .clk(clk), .rst(rst), .en(en), .d(xn), .q(xn_a)
  );

  // k4
  rk4_slope #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_k4 (
    .clk(clk), .rst(rst), .en(en), .h(h), .x(xn_a), .y(y4),
    .ctl_in(c4p), .k(k4), .ctl_out(c4)
  );

  // align all slopes with k4
  rk4_delay #(.WIDTH(WORD_WIDTH), .DEPTH(3 * S + 2 * P + 1)) u_dk1 (
    .clk(clk), .rst(rst), .en(en), .d(k1), .q(k1d)
  );

  rk4_delay #(.WIDTH(WORD_WIDTH), .DEPTH(2 * S + P + 1)) u_dk2 (
    .clk(clk), .rst(rst), .en(en), .d(k2), .q(k2d)
  );

  rk4_delay #(.WIDTH(WORD_WIDTH), .DEPTH(S + 1)) u_dk3 (
    .clk(clk), .rst(rst), .en(en), .d(k3), .q(k3d)
  );

  rk4_cdiv #(.WORD_WIDTH(WORD_WIDTH), .DIVISOR(rk4_pkg::DIV_EDGE)) u_q1 (
    .clk(clk), .en(en), .v(k1d), .q(q1)
  );

  rk4_cdiv #(.WORD_WIDTH(WORD_WIDTH), .DIVISOR(rk4_pkg::DIV_MID)) u_q2 (
    .clk(clk), .en(en), .v(k2d), .q(q2)
  );

  rk4_cdiv #(.WORD_WIDTH(WORD_WIDTH), .DIVISOR(rk4_pkg::DIV_MID)) u_q3 (
    .clk(clk), .en(en), .v(k3d), .q(q3)
  );

  rk4_cdiv #(.WORD_WIDTH(WORD_WIDTH), .DIVISOR(rk4_pkg::DIV_EDGE)) u_q4 (
    .clk(clk), .en(en), .v(k4), .q(q4)
  );

  rk4_delay #(.WIDTH($bits(rk4_pkg::ctl_t)), .DEPTH(DIV_LAT)) u_dc (
    .clk(clk), .rst(rst), .en(en), .d(c4), .q(cq)
  );

  rk4_delay #(.WIDTH(WORD_WIDTH), .DEPTH(S + 1 + DIV_LAT)) u_dy_d (
    .clk(clk), .rst(rst), .en(en), .d(yc), .q(yd)
  );

  rk4_delay #(.WIDTH(WORD_WIDTH), .DEPTH(S + DIV_LAT)) u_dxn_b (
    .clk(clk), .rst(rst), .en(en), .d(xn_a), .q(xn_b)
  );

  // accumulate left to right, saturating at each add
  rk4_sat_add #(.WORD_WIDTH(WORD_WIDTH)) u_e1 (
    .a(yd), .b(q1), .sum(a1), .sat(s1)
  );

  rk4_sat_add #(.WORD_WIDTH(WORD_WIDTH)) u_e2 (
    .a(e1_acc), .b(e1_q2), .sum(a2), .sat(s2)
  );

  rk4_sat_add #(.WORD_WIDTH(WORD_WIDTH)) u_e3 (
    .a(e2_acc), .b(e2_q3), .sum(a3), .sat(s3)
  );

  rk4_sat_add #(.WORD_WIDTH(WORD_WIDTH)) u_e4 (
    .a(e3_acc), .b(e3_q4), .sum(a4), .sat(s4)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      e1_acc <= a1;
      e1_q2  <= q2;
      e1_q3  <= q3;
      e1_q4  <= q4;
      e1_x   <= xn_b;
      e2_acc <= a2;
      e2_q3  <= e1_q3;
      e2_q4  <= e1_q4;
      e2_x   <= e1_x;
      e3_acc <= a3;
      e3_q4  <= e2_q4;
      e3_x   <= e2_x;
      y_next <= a4;
      x_next <= e3_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_ctl    <= '0;
      e2_ctl    <= '0;
      e3_ctl    <= '0;
      out_valid <= 1'b0;
      overflow  <= 1'b0;
    end else if (en) begin
      e1_ctl.valid <= cq.valid;
      e1_ctl.ovf   <= cq.ovf | s1;
      e2_ctl.valid <= e1_ctl.valid;
      e2_ctl.ovf   <= e1_ctl.ovf | s2;
      e3_ctl.valid <= e2_ctl.valid;
      e3_ctl.ovf   <= e2_ctl.ovf | s3;
      out_valid    <= e3_ctl.valid;
      overflow     <= e3_ctl.ovf | s4;
    end
  end

endmodule

// ===== tb/rk4_ode_step_unit_tb.sv =====
// Self-checking testbench for rk4_ode_step_unit: an RK4 step predictor in a scoreboard
// class, with random bursts on the request side and random stalls on the result side.
// Depends on rk4_pkg and the rk4_ode_step_unit RTL only.
module rk4_ode_step_unit_tb;

  localparam int W          = rk4_pkg::WORD_WIDTH_DEF;
  localparam int SB         = rk4_pkg::STEP_BITS;
  localparam int LAT_WAIT   = 60;
  localparam int CYCLE_CAP  = 400000;
  localparam int PHASE_REQS = 300;

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE  = 1 <<< rk4_pkg::FRAC_BITS_DEF;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  typedef struct {
    logic signed [W-1:0] y;
    logic signed [W-1:0] x;
    logic                ovf;
  } step_result_t;

  class rk4_step_board;
    localparam longint VMAX = (64'sd1 <<< (W - 1)) - 1;
    localparam longint VMIN = -VMAX - 1;
    localparam int     FB   = rk4_pkg::FRAC_BITS_DEF;

    logic [SB-1:0] step;
    bit            sat;
    step_result_t  pending_steps[$];
    int            errors;
    int            checked;
    int            saturated;

    function new();
      step = rk4_pkg::STEP_RESET;
      errors = 0;
      checked = 0;
      saturated = 0;
    endfunction

    function longint unsigned mag_of(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function longint clamp(bit neg, longint unsigned m);
      if (!neg) begin
        if (m > VMAX) begin
          sat = 1'b1;
          return VMAX;
        end
        return m;
      end
      if (m > VMAX + 1) begin
        sat = 1'b1;
        return VMIN;
      end
      return -longint'(m);
    endfunction

    function longint add_clamp(longint a, longint b);
      longint s;
      s = a + b;
      if (s > VMAX) begin
        sat = 1'b1;
        return VMAX;
      end
      if (s < VMIN) begin
        sat = 1'b1;
        return VMIN;
      end
      return s;
    endfunction

    function longint mul_q(longint a, longint b);
      longint unsigned p;
      p = mag_of(a) * mag_of(b) + (64'd1 << (FB - 1));
      return clamp((a < 0) != (b < 0), p >> FB);
    endfunction

    function longint div_round(longint v, longint unsigned d);
      longint unsigned m;
      longint unsigned q;
      m = mag_of(v);
      q = m / d + ((((m % d) * 2) >= d) ? 1 : 0);
      return clamp(v < 0, q);
    endfunction

    function longint slope(longint h, longint x, longint y);
      return mul_q(h, add_clamp(mul_q(x, x), mul_q(y, y)));
    endfunction

    function void note_point(logic signed [W-1:0] x_in, logic signed [W-1:0] y_in);
      longint x, y, h, hh, xh, xn, k1, k2, k3, k4, yn;
      step_result_t r;
      x = x_in;
      y = y_in;
      sat = 1'b0;
      h  = clamp(1'b0, step);
      hh = div_round(h, 2);
      xh = add_clamp(x, hh);
      xn = add_clamp(x, h);
      k1 = slope(h, x, y);
      k2 = slope(h, xh, add_clamp(y, div_round(k1, 2)));
      k3 = slope(h, xh, add_clamp(y, div_round(k2, 2)));
      k4 = slope(h, xn, add_clamp(y, k3));
      yn = add_clamp(y, div_round(k1, 6));
      yn = add_clamp(yn, div_round(k2, 3));
      yn = add_clamp(yn, div_round(k3, 3));
      yn = add_clamp(yn, div_round(k4, 6));
      r.y = W'(yn);
      r.x = W'(xn);
      r.ovf = sat;
      pending_steps.push_back(r);
    endfunction

    function void check_step(logic signed [W-1:0] y, logic signed [W-1:0] x, logic ovf);
      step_result_t e;
      if (pending_steps.size() == 0) begin
        $error("unexpected result: y_next %0d x_next %0d overflow %0b", y, x, ovf);
        errors++;
        return;
      end
      e = pending_steps.pop_front();
      checked++;
      if (e.ovf) saturated++;
      if (y !== e.y) begin
        $error("y_next mismatch: expected %0d, actual %0d", e.y, y);
        errors++;
      end
      if (x !== e.x) begin
        $error("x_next mismatch: expected %0d, actual %0d", e.x, x);
        errors++;
      end
      if (ovf !== e.ovf) begin
        $error("overflow mismatch: expected %0b, actual %0b", e.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic signed [W-1:0] x_now = '0;
  logic signed [W-1:0] y_now = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic signed [W-1:0] y_next;
  logic signed [W-1:0] x_next;
  logic                overflow;
  logic                cfg_wr_en = 1'b0;
  logic [SB-1:0]       cfg_wr_data = '0;

  rk4_step_board board;
  int            cycle_count = 0;
  int            step_writes = 0;
  stall_mode_t   stall_mode = STALL_NONE;
  int            stall_left = 0;
  int            period_pos = 0;

  rk4_ode_step_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .x_now      (x_now),
    .y_now      (y_now),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .y_next     (y_next),
    .x_next     (x_next),
    .overflow   (overflow),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("rk4_ode_step_unit test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.note_point(x_now, y_now);
      if (out_valid && !out_stall) board.check_step(y_next, x_next, overflow);
    end
  end

  // pick a new stall pattern whenever the current one runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(3));
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    period_pos <= (period_pos + 1) % 16;
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_LIGHT:  out_stall <= ($urandom_range(99) < 25);
      STALL_HEAVY:  out_stall <= ($urandom_range(99) < 75);
      default:      out_stall <= (period_pos >= 10);
    endcase
  end

  function automatic logic signed [W-1:0] pick_coord();
    case ($urandom_range(9))
      0, 1:       return $urandom;
      2, 3, 4, 5: return W'(int'($urandom_range(262144)) - 131072);
      6, 7:       return W'(int'($urandom_range(1048576)) - 524288);
      8:          return W'(int'($urandom_range(65536)) - 32768);
      default:    return W'(int'($urandom_range(33554432)) - 16777216);
    endcase
  endfunction

  task automatic send_point(input logic signed [W-1:0] x, input logic signed [W-1:0] y);
    in_valid <= 1'b1;
    x_now <= x;
    y_now <= y;
    do @(posedge clk); while (in_stall);
  endtask

  // expects in_valid already low
  task automatic settle_pipeline();
    while (board.pending_steps.size() != 0) @(posedge clk);
    repeat (LAT_WAIT) @(posedge clk);
  endtask

  task automatic write_step(input logic [SB-1:0] h);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= h;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.step = h;
    step_writes++;
  endtask

  task automatic run_points(input int n, input bit gappy, input bit pause_mid);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < n; i++) begin
        send_point(pick_coord(), pick_coord());
        sent++;
      end
      gap = (gappy && $urandom_range(2) != 0) ? $urandom_range(1, 8) : 0;
      if (pause_mid && sent >= n / 2) begin
        pause_mid = 1'b0;
        in_valid <= 1'b0;
        settle_pipeline();
      end else if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    logic [SB-1:0] step_plan[6];
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_point('0, '0);
    send_point(ONE, ONE);
    send_point(-ONE, -ONE);
    send_point(WMAX, '0);
    send_point('0, WMAX);
    send_point(WMIN, '0);
    send_point('0, WMIN);
    send_point(WMIN, WMIN);
    send_point(WMAX, WMAX);
    send_point(-1, 1);
    send_point(1, -1);
    send_point(WMAX - 100, '0);
    send_point(ONE >>> 1, -(ONE >>> 1));
    send_point(2 * ONE, 3 * ONE);
    send_point(-2 * ONE, 32'sh0000_5555);
    send_point(WMIN, ONE);
    in_valid <= 1'b0;
    settle_pipeline();

    step_plan = '{1, 65536, 32768, rk4_pkg::STEP_RESET, $urandom_range(1, 65536),
                  $urandom_range(1, 65536)};
    foreach (step_plan[i]) begin
      write_step(step_plan[i]);
      run_points(PHASE_REQS, i != 2, i == 1);
      in_valid <= 1'b0;
      settle_pipeline();
    end

    $display("covered %0d requests over %0d step sizes plus the reset step",
             board.checked, step_writes);
    $display("%0d results saturated, %0d cycles", board.saturated, cycle_count);
    if (board.errors == 0 && board.pending_steps.size() == 0) begin
      $display("rk4_ode_step_unit test passed");
    end else begin
      $display("rk4_ode_step_unit test failed");
    end
    $finish;
  end

endmodule

// ===== rk4_ode_step_unit.f =====
rtl/rk4_pkg.sv
rtl/rk4_sat_add.sv
rtl/rk4_mul.sv
rtl/rk4_delay.sv
rtl/rk4_slope.sv
rtl/rk4_pre.sv
rtl/rk4_cdiv.sv
rtl/rk4_ode_step_unit.sv
tb/rk4_ode_step_unit_tb.sv
